// ===== sv/tmp_pkg.sv =====
// Shared types and codes of the trapezoidal motion profile block.
`timescale 1ns / 1ps

package tmp_pkg;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_ACCEL  = 2'd1,
    PH_CRUISE = 2'd2,
    PH_DECEL  = 2'd3
  } phase_t;

  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_CEIL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_CEIL = 1'd1;

  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_START = 1'b1;

endpackage

// ===== sv/trapezoidal_motion_profile_top.sv =====
// Top level of the one-axis trapezoidal motion profile generator.
//
//   channel | ports                                         | handshake
//   --------+-----------------------------------------------+---------------------
//   cfg     | cfg_we, cfg_index, cfg_wdata                  | write when cfg_we
//   in      | in_req_type, in_start_position, in_move_...   | in_valid & in_ready
//   out     | out_setpoint, out_phase, out_current_speed,.. | out_valid & out_ready
//
// Throughput is one item per cycle while out_ready is high. A taken item is written
// into the queue and sits at the queue head while the move engine evaluates the
// whole phase chain; the result register loads when the item is popped.
// Reset clears the move to idle and the ceilings to all ones; no clearing pass.
// in_ready drops only when the two-entry queue is full; the output register
// drains the queue whenever it is empty or out_ready is high, so either side may stall.
`timescale 1ns / 1ps

module trapezoidal_motion_profile_top #(
  parameter int unsigned POS_WIDTH   = 32,
  parameter int unsigned SPEED_WIDTH = 24
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration
  input  logic                           cfg_we,
  input  logic [tmp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [SPEED_WIDTH-1:0]         cfg_wdata,
  // request items
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_req_type,
  input  logic signed [POS_WIDTH-1:0]    in_start_position,
  input  logic signed [POS_WIDTH-1:0]    in_move_distance,
  input  logic signed [SPEED_WIDTH:0]    in_speed_limit,
  input  logic signed [SPEED_WIDTH:0]    in_accel_limit,
  // result items
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [POS_WIDTH-1:0]    out_setpoint,
  output logic [1:0]                     out_phase,
  output logic [SPEED_WIDTH-1:0]         out_current_speed,
  output logic                           out_done_res
);

  // start flag, origin, direction, length, top speed, accel step
  localparam int unsigned ENTRY_W = 2 * POS_WIDTH + 2 * SPEED_WIDTH + 2;

  logic [ENTRY_W-1:0] front_entry;
  logic [ENTRY_W-1:0] q_data;
  logic               q_full;
  logic               q_valid;
  logic               q_pop;
  logic               push;

  // Take a new item whenever the queue has room.
  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  // Classify the item and clamp its limits against the ceilings.
  tmp_front #(
    .POS_WIDTH   (POS_WIDTH),
    .SPEED_WIDTH (SPEED_WIDTH),
    .ENTRY_W     (ENTRY_W)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .req_type       (in_req_type),
    .start_position (in_start_position),
    .move_distance  (in_move_distance),
    .speed_limit    (in_speed_limit),
    .accel_limit    (in_accel_limit),
    .entry          (front_entry)
  );

  // Decouple the request side from the move engine.
  tmp_queue #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (front_entry),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_data)
  );

  // Load a move per popped start item, advance the profile one tick per popped tick item, and hold the result.
  tmp_back #(
    .POS_WIDTH   (POS_WIDTH),
    .SPEED_WIDTH (SPEED_WIDTH),
    .ENTRY_W     (ENTRY_W)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_data            (q_data),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_setpoint      (out_setpoint),
    .out_phase         (out_phase),
    .out_current_speed (out_current_speed),
    .out_done_res      (out_done_res)
  );

endmodule

// ===== sv/tmp_front.sv =====
// Front end: ceiling registers, item classification and limit clamping.
`timescale 1ns / 1ps

module tmp_front #(
  parameter int unsigned POS_WIDTH   = 32,
  parameter int unsigned SPEED_WIDTH = 24,
  parameter int unsigned ENTRY_W     = 2 * POS_WIDTH + 2 * SPEED_WIDTH + 2
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [tmp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [SPEED_WIDTH-1:0]         cfg_wdata,
  input  logic                           req_type,
  input  logic signed [POS_WIDTH-1:0]    start_position,
  input  logic signed [POS_WIDTH-1:0]    move_distance,
  input  logic signed [SPEED_WIDTH:0]    speed_limit,
  input  logic signed [SPEED_WIDTH:0]    accel_limit,
  output logic [ENTRY_W-1:0]             entry
);

  logic [SPEED_WIDTH-1:0] speed_ceil_r;
  logic [SPEED_WIDTH-1:0] accel_ceil_r;
  logic [POS_WIDTH-1:0]   length;
  logic [SPEED_WIDTH-1:0] top;
  logic [SPEED_WIDTH-1:0] step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_ceil_r <= '1;
      accel_ceil_r <= '1;
    end else if (cfg_we) begin
      case (cfg_index)
        tmp_pkg::CFG_SPEED_CEIL: speed_ceil_r <= cfg_wdata;
        tmp_pkg::CFG_ACCEL_CEIL: accel_ceil_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Magnitude of the distance; the most negative value maps to 2^(P-1).
  assign length = move_distance[POS_WIDTH-1] ? (~move_distance + 1'b1) : move_distance;

  // Clamp requested limits to [0, ceiling].
  always_comb begin
    if (speed_limit[SPEED_WIDTH])
      top = '0;
    else if (speed_limit[SPEED_WIDTH-1:0] > speed_ceil_r)
      top = speed_ceil_r;
    else
      top = speed_limit[SPEED_WIDTH-1:0];

    if (accel_limit[SPEED_WIDTH])
      step = '0;
    else if (accel_limit[SPEED_WIDTH-1:0] > accel_ceil_r)
      step = accel_ceil_r;
    else
      step = accel_limit[SPEED_WIDTH-1:0];
  end

  assign entry = {req_type, start_position, move_distance[POS_WIDTH-1], length, top, step};

endmodule

// ===== sv/tmp_queue.sv =====
// Two-entry queue between the front end and the move engine.
`timescale 1ns / 1ps

module tmp_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       count_r;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign pop_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push) else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !not_empty |-> !pop) else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3) else $error("queue count out of range");
`endif

endmodule

// ===== sv/tmp_back.sv =====
// Move engine: phase sequencing, speed and distance integration, result register.
`timescale 1ns / 1ps

module tmp_back #(
  parameter int unsigned POS_WIDTH   = 32,
  parameter int unsigned SPEED_WIDTH = 24,
  parameter int unsigned ENTRY_W     = 2 * POS_WIDTH + 2 * SPEED_WIDTH + 2
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  input  logic [ENTRY_W-1:0]          q_data,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [POS_WIDTH-1:0] out_setpoint,
  output logic [1:0]                  out_phase,
  output logic [SPEED_WIDTH-1:0]      out_current_speed,
  output logic                        out_done_res
);

  localparam int unsigned TW   = POS_WIDTH + 1;
  localparam int unsigned SUMW = ((TW > SPEED_WIDTH) ? TW : SPEED_WIDTH) + 1;
  localparam logic [SUMW-1:0] TRAV_MAX = SUMW'({TW{1'b1}});

  // Unpacked queue entry
  logic                   e_start;
  logic [POS_WIDTH-1:0]   e_origin;
  logic                   e_neg;
  logic [POS_WIDTH-1:0]   e_length;
  logic [SPEED_WIDTH-1:0] e_top;
  logic [SPEED_WIDTH-1:0] e_step;

  assign {e_start, e_origin, e_neg, e_length, e_top, e_step} = q_data;

  // Move state
  logic [POS_WIDTH-1:0]   origin_r,    origin_nxt;
  logic [POS_WIDTH-1:0]   total_r,     total_nxt;
  logic                   neg_r,       neg_nxt;
  logic [SPEED_WIDTH-1:0] top_r,       top_nxt;
  logic [SPEED_WIDTH-1:0] step_r,      step_nxt;
  logic [SPEED_WIDTH-1:0] speed_r,     speed_nxt;
  logic [SPEED_WIDTH-1:0] sbefore_r,   sbefore_nxt;
  logic [TW-1:0]          trav_r,      trav_nxt;
  logic [POS_WIDTH-1:0]   ramp_r,      ramp_nxt;
  tmp_pkg::phase_t        phase_r,     phase_nxt;

  // Result register
  logic                        out_valid_r, out_valid_nxt;
  logic signed [POS_WIDTH-1:0] out_sp_r,    out_sp_nxt;
  tmp_pkg::phase_t             out_ph_r,    out_ph_nxt;
  logic [SPEED_WIDTH-1:0]      out_spd_r,   out_spd_nxt;
  logic                        out_done_r,  out_done_nxt;

  // Tick evaluation
  logic                   acc_go, cru_here, cru_go, dec_here, dec_go, any_go;
  logic [POS_WIDTH-1:0]   trav_sat;
  logic [POS_WIDTH-1:0]   ramp_eff;
  logic [SPEED_WIDTH:0]   s_acc;
  logic [SPEED_WIDTH-1:0] s_acc_cl;
  logic [SPEED_WIDTH-1:0] s_dec;
  logic [SPEED_WIDTH-1:0] s_new;
  logic [SPEED_WIDTH:0]   pair_sum;
  logic [SPEED_WIDTH-1:0] inc;
  logic [SUMW-1:0]        trav_sum;
  logic [TW-1:0]          trav_new;
  logic [POS_WIDTH-1:0]   dist_sel;
  logic [POS_WIDTH-1:0]   pos_off;
  tmp_pkg::phase_t        tick_phase;

  assign q_pop = q_valid && (!out_valid_r || out_ready);

  always_comb begin
    trav_sat = trav_r[TW-1] ? '1 : trav_r[POS_WIDTH-1:0];
    acc_go   = (phase_r == tmp_pkg::PH_ACCEL) && (speed_r < top_r)
               && ({trav_r, 1'b0} < (POS_WIDTH + 2)'(total_r));
    ramp_eff = (phase_r == tmp_pkg::PH_ACCEL) ? trav_sat : ramp_r;
    cru_here = ((phase_r == tmp_pkg::PH_ACCEL) && !acc_go) || (phase_r == tmp_pkg::PH_CRUISE);
    cru_go   = cru_here
               && (((POS_WIDTH + 2)'(trav_r) + (POS_WIDTH + 2)'(ramp_eff))
                   < (POS_WIDTH + 2)'(total_r));
    dec_here = (cru_here && !cru_go) || (phase_r == tmp_pkg::PH_DECEL);
    dec_go   = dec_here && (speed_r != '0) && (trav_r < TW'(total_r));
    any_go   = acc_go || cru_go || dec_go;

    s_acc    = {1'b0, speed_r} + {1'b0, step_r};
    s_acc_cl = (s_acc > {1'b0, top_r}) ? top_r : s_acc[SPEED_WIDTH-1:0];
    s_dec    = (speed_r > step_r) ? (speed_r - step_r) : '0;

    if (acc_go) begin
      s_new      = s_acc_cl;
      tick_phase = tmp_pkg::PH_ACCEL;
    end else if (cru_go) begin
      s_new      = speed_r;
      tick_phase = tmp_pkg::PH_CRUISE;
    end else if (dec_go) begin
      s_new      = s_dec;
      tick_phase = tmp_pkg::PH_DECEL;
    end else begin
      s_new      = '0;
      tick_phase = tmp_pkg::PH_IDLE;
    end

    // Trapezoid step on ramps, rectangle step when cruising
    pair_sum = {1'b0, sbefore_r} + {1'b0, s_new};
    inc      = cru_go ? speed_r : pair_sum[SPEED_WIDTH:1];
    trav_sum = SUMW'(trav_r) + SUMW'(inc);
    trav_new = (trav_sum > TRAV_MAX) ? '1 : trav_sum[TW-1:0];

    dist_sel = any_go ? trav_new[POS_WIDTH-1:0] : total_r;
    pos_off  = neg_r ? (origin_r - dist_sel) : (origin_r + dist_sel);
  end

  // Next state
  always_comb begin
    origin_nxt  = origin_r;
    total_nxt   = total_r;
    neg_nxt     = neg_r;
    top_nxt     = top_r;
    step_nxt    = step_r;
    speed_nxt   = speed_r;
    sbefore_nxt = sbefore_r;
    trav_nxt    = trav_r;
    ramp_nxt    = ramp_r;
    phase_nxt   = phase_r;
    if (q_pop) begin
      if (e_start == tmp_pkg::REQ_START) begin
        origin_nxt  = e_origin;
        total_nxt   = e_length;
        neg_nxt     = e_neg;
        top_nxt     = e_top;
        step_nxt    = e_step;
        speed_nxt   = '0;
        sbefore_nxt = '0;
        trav_nxt    = '0;
        ramp_nxt    = '0;
        phase_nxt   = tmp_pkg::PH_ACCEL;
      end else begin
        speed_nxt   = s_new;
        sbefore_nxt = s_new;
        phase_nxt   = tick_phase;
        if (any_go) trav_nxt = trav_new;
        if ((phase_r == tmp_pkg::PH_ACCEL) && !acc_go) ramp_nxt = trav_sat;
      end
    end
  end

  // Outputs
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_sp_nxt    = out_sp_r;
    out_ph_nxt    = out_ph_r;
    out_spd_nxt   = out_spd_r;
    out_done_nxt  = out_done_r;
    if (q_pop) begin
      out_valid_nxt = 1'b1;
      if (e_start == tmp_pkg::REQ_START) begin
        out_sp_nxt   = e_origin;
        out_ph_nxt   = tmp_pkg::PH_ACCEL;
        out_spd_nxt  = '0;
        out_done_nxt = 1'b0;
      end else begin
        out_sp_nxt   = pos_off;
        out_ph_nxt   = tick_phase;
        out_spd_nxt  = s_new;
        out_done_nxt = !any_go;
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_r    <= '0;
      total_r     <= '0;
      neg_r       <= 1'b0;
      top_r       <= '0;
      step_r      <= '0;
      speed_r     <= '0;
      sbefore_r   <= '0;
      trav_r      <= '0;
      ramp_r      <= '0;
      phase_r     <= tmp_pkg::PH_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      origin_r    <= origin_nxt;
      total_r     <= total_nxt;
      neg_r       <= neg_nxt;
      top_r       <= top_nxt;
      step_r      <= step_nxt;
      speed_r     <= speed_nxt;
      sbefore_r   <= sbefore_nxt;
      trav_r      <= trav_nxt;
      ramp_r      <= ramp_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_sp_r   <= out_sp_nxt;
    out_ph_r   <= out_ph_nxt;
    out_spd_r  <= out_spd_nxt;
    out_done_r <= out_done_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_setpoint      = out_sp_r;
  assign out_phase         = out_ph_r;
  assign out_current_speed = out_spd_r;
  assign out_done_res      = out_done_r;

`ifndef SYNTHESIS
  a_speed_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    speed_r <= top_r) else $error("speed above top speed");
  a_idle_at_rest: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == tmp_pkg::PH_IDLE) |-> (speed_r == '0) && (sbefore_r == '0))
    else $error("idle with nonzero speed");
  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_done_r) |-> (out_ph_r == tmp_pkg::PH_IDLE) && (out_spd_r == '0))
    else $error("done result not at rest");
  a_pop_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> out_valid_r) else $error("popped item produced no result");
`endif

endmodule
